// ===== hdl/hcbp_pkg.sv =====
// hcbp_pkg: shared constants and payload types of the huffman code bit packer
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN  = 32;
    localparam int ALPHABET_SIZE = 256;
    localparam int TABLE_DEPTH   = 256;
    localparam int BYTE_W        = 8;
    localparam int SYM_W         = 8;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int MODE_W        = 2;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    // bit accumulator: up to seven held bits plus one longest code
    localparam int ACC_W         = MAX_CODE_LEN + BYTE_W - 1;
    localparam int NB_W          = $clog2(ACC_W + 1);

    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  symbol_byte;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } out_t;

endpackage

`default_nettype wire

// ===== hdl/huffman_code_bit_packer_unit.sv =====
// huffman_code_bit_packer_unit: code table memory and lsb-first bit packer
//
//   channel   dir  handshake          payload
//   s_        in   s_valid / s_ready  hcbp_pkg::in_t  (mode, symbol, code, length)
//   m_        out  m_valid / m_ready  hcbp_pkg::out_t (packed byte, last flag)
//
// a load finishes in the table write; a flush goes to the emit state and sends
// the partial byte if bits are held; an encode steps through accept, synchronous
// table read, append in the lookup state, each completed byte sent from the emit
// state, then leftover bits back to the partial byte; one item is in work at a time
// aresetn clears the control state and the partial byte; the table holds
// garbage until each entry is loaded, there is no clearing pass
// a stalled m_ready holds the byte in the output register and stops emission;
// the next transfer on s_ is taken while the last byte still waits
`default_nettype none

module huffman_code_bit_packer_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire hcbp_pkg::in_t   s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output hcbp_pkg::out_t       m_payload
);

    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a transfer
    localparam logic [1:0] ST_LOOK = 2'd1;   // table read data arrives
    localparam logic [1:0] ST_EMIT = 2'd2;   // sending completed bytes

    localparam int NB_W  = hcbp_pkg::NB_W;
    localparam int ACC_W = hcbp_pkg::ACC_W;

    // code table, one synchronous memory for codes and one for lengths
    logic [hcbp_pkg::CODE_W-1:0] code_mem [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::LEN_W-1:0]  len_mem  [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::CODE_W-1:0] rd_code_reg;
    logic [hcbp_pkg::LEN_W-1:0]  rd_len_reg;

    logic [1:0]                  state_reg, state_next;
    logic [hcbp_pkg::BYTE_W-1:0] pending_reg, pending_next;
    logic [2:0]                  bitpos_reg, bitpos_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [NB_W-1:0]             nbits_reg, nbits_next;
    logic                        m_valid_reg, m_valid_next;
    hcbp_pkg::out_t              m_data_reg, m_data_next;

    logic                        s_xfer;
    logic                        sym_ok;
    logic [hcbp_pkg::IDX_W-1:0]  tbl_idx;
    logic [hcbp_pkg::LEN_W-1:0]  load_len;
    logic [ACC_W-1:0]            code_mask;
    logic                        out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign tbl_idx   = s_payload.symbol_byte[hcbp_pkg::IDX_W-1:0];

    // symbols at or above the alphabet size are dropped
    assign sym_ok = ({1'b0, s_payload.symbol_byte} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::ALPHABET_SIZE))
                 && ({1'b0, s_payload.symbol_byte} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::TABLE_DEPTH));

    // long lengths saturate at the maximum code length
    assign load_len = (s_payload.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN))
                    ? hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : s_payload.code_length;

    // only the low length bits of a code are sent
    assign code_mask = (ACC_W'(1) << rd_len_reg) - ACC_W'(1);

    // table write on a load transfer, table read on every transfer
    always_ff @(posedge aclk) begin
        if (s_xfer && sym_ok && (s_payload.mode == hcbp_pkg::MODE_LOAD)) begin
            code_mem[tbl_idx] <= s_payload.code_bits;
            len_mem[tbl_idx]  <= load_len;
        end
        if (s_xfer) begin
            rd_code_reg <= code_mem[tbl_idx];
            rd_len_reg  <= len_mem[tbl_idx];
        end
    end

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        bitpos_next  = bitpos_reg;
        acc_next     = acc_reg;
        nbits_next   = nbits_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_payload.mode)
                        hcbp_pkg::MODE_ENCODE: begin
                            if (sym_ok) begin
                                state_next = ST_LOOK;
                            end
                        end
                        hcbp_pkg::MODE_FLUSH: begin
                            // pending high bits are always zero, so send it as a full byte
                            acc_next   = ACC_W'(pending_reg);
                            nbits_next = (bitpos_reg != 3'd0) ? NB_W'(hcbp_pkg::BYTE_W)
                                                              : NB_W'(0);
                            state_next = ST_EMIT;
                        end
                        default: begin
                            // loads finish in the memory write, unused mode is dropped
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                // append the code above the bits already held
                acc_next   = ACC_W'(pending_reg)
                           | ((ACC_W'(rd_code_reg) & code_mask) << bitpos_reg);
                nbits_next = NB_W'(bitpos_reg) + NB_W'(rd_len_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (nbits_reg >= NB_W'(hcbp_pkg::BYTE_W)) begin
                    if (out_free) begin
                        m_data_next.out_byte    = acc_reg[hcbp_pkg::BYTE_W-1:0];
                        m_data_next.last_of_run = (nbits_reg < NB_W'(2*hcbp_pkg::BYTE_W));
                        m_valid_next = 1'b1;
                        acc_next     = acc_reg >> hcbp_pkg::BYTE_W;
                        nbits_next   = nbits_reg - NB_W'(hcbp_pkg::BYTE_W);
                    end
                end else begin
                    // leftover bits become the partial byte
                    pending_next = acc_reg[hcbp_pkg::BYTE_W-1:0];
                    bitpos_next  = nbits_reg[2:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= '0;
            bitpos_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            bitpos_reg  <= bitpos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        nbits_reg  <= nbits_next;
        m_data_reg <= m_data_next;
    end

    // a table lookup always follows an accepted transfer
    a_look_after_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> ($past(state_reg) == ST_IDLE))
        else $error("lookup state not entered from idle");

    // bits above the held count stay zero while packing
    a_acc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ((acc_reg >> nbits_reg) == '0))
        else $error("stray bits in packing accumulator");

    // a new byte only appears from the emit state
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("output byte raised outside emit");

    // the held bit count never exceeds one partial byte plus a longest code
    a_nbits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (nbits_reg <= NB_W'(ACC_W)))
        else $error("bit count out of range");

endmodule

`default_nettype wire

// ===== bench/bit_stream_checker.sv =====
// bit_stream_checker: predicts the packed byte stream of the bit packer and checks its output
`timescale 1ns / 100ps

module bit_stream_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire hcbp_pkg::in_t  s_payload,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire hcbp_pkg::out_t m_payload,
    output int                  mismatch_count,
    output int                  bytes_awaited
);

    logic [hcbp_pkg::CODE_W-1:0] code_table   [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::LEN_W-1:0]  length_table [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::BYTE_W-1:0] partial_byte;
    int unsigned                 bits_held;
    hcbp_pkg::out_t              expected_bytes [$];

    // applies one input transfer to the shadow table and bit stream
    task automatic predict_packed_bytes(input hcbp_pkg::in_t item);
        logic [hcbp_pkg::LEN_W-1:0] len;
        hcbp_pkg::out_t             burst [$];
        hcbp_pkg::out_t             entry;
        int                         i;
        len = item.code_length;
        if (item.symbol_byte < hcbp_pkg::ALPHABET_SIZE || item.mode == hcbp_pkg::MODE_FLUSH) begin
            case (item.mode)
                hcbp_pkg::MODE_LOAD: begin
                    if (len > hcbp_pkg::MAX_CODE_LEN) begin
                        len = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
                    end
                    code_table[item.symbol_byte]   = item.code_bits;
                    length_table[item.symbol_byte] = len;
                end
                hcbp_pkg::MODE_ENCODE: begin
                    for (i = 0; i < length_table[item.symbol_byte]; i++) begin
                        partial_byte[bits_held] = code_table[item.symbol_byte][i];
                        bits_held++;
                        if (bits_held == hcbp_pkg::BYTE_W) begin
                            entry.out_byte    = partial_byte;
                            entry.last_of_run = 1'b0;
                            burst             = {burst, entry};
                            partial_byte      = '0;
                            bits_held         = 0;
                        end
                    end
                end
                hcbp_pkg::MODE_FLUSH: begin
                    if (bits_held != 0) begin
                        entry.out_byte    = partial_byte;
                        entry.last_of_run = 1'b0;
                        burst             = {burst, entry};
                        partial_byte      = '0;
                        bits_held         = 0;
                    end
                end
                default: ;
            endcase
        end
        if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
        expected_bytes = {expected_bytes, burst};
    endtask

    always @(posedge aclk) begin
        hcbp_pkg::out_t want;
        int             errs;
        errs = 0;
        if (!aresetn) begin
            partial_byte = '0;
            bits_held    = 0;
            expected_bytes.delete();
            mismatch_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual %02h last %b",
                             $time, m_payload.out_byte, m_payload.last_of_run);
                    errs++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_payload.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, m_payload.out_byte);
                        errs++;
                    end
                    if (m_payload.last_of_run !== want.last_of_run) begin
                        $display("%0t: last_of_run expected %b actual %b",
                                 $time, want.last_of_run, m_payload.last_of_run);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) predict_packed_bytes(s_payload);
            mismatch_count <= mismatch_count + errs;
        end
        bytes_awaited <= expected_bytes.size();
    end

endmodule

// ===== bench/testbench.sv =====
// testbench: stimulus, flow control and verdict for the huffman code bit packer
`timescale 1ns / 100ps

module testbench;

    // mode 3 has no function in the block, it must be dropped silently
    localparam logic [hcbp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_PERCENT    = 32;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    hcbp_pkg::in_t  s_payload = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    hcbp_pkg::out_t m_payload;

    int mismatch_count;
    int bytes_awaited;
    int cycle_count = 0;
    int hold_left   = 0;

    // shared knobs between the stimulus thread and the receiver
    bit gaps_enabled     = 1'b1;
    bit hold_off_request = 1'b0;

    // which table entries hold a code, so that encodes only hit written entries
    bit [hcbp_pkg::TABLE_DEPTH-1:0] entry_loaded = '0;
    logic [hcbp_pkg::SYM_W-1:0]     loaded_symbols [$];

    always #5 aclk = ~aclk;

    huffman_code_bit_packer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    bit_stream_checker stream_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .mismatch_count (mismatch_count),
        .bytes_awaited  (bytes_awaited)
    );

    // result side: random back-pressure, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_request) begin
            // take the request and count the stall out here
            m_ready          <= 1'b0;
            hold_left        <= HOLD_OFF_CYCLES;
            hold_off_request <= 1'b0;
        end else begin
            m_ready <= !gaps_enabled || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic hcbp_pkg::in_t make_item(input logic [hcbp_pkg::MODE_W-1:0] mode,
                                                input logic [hcbp_pkg::SYM_W-1:0]  sym,
                                                input logic [hcbp_pkg::CODE_W-1:0] code,
                                                input logic [hcbp_pkg::LEN_W-1:0]  len);
        hcbp_pkg::in_t item;
        item.mode        = mode;
        item.symbol_byte = sym;
        item.code_bits   = code;
        item.code_length = len;
        return item;
    endfunction

    // mostly encodes of loaded symbols, some table writes, flushes and noise
    function automatic hcbp_pkg::in_t random_item(input bit encode_heavy);
        hcbp_pkg::in_t item;
        int            pick;
        item.mode        = MODE_UNUSED;
        item.symbol_byte = hcbp_pkg::SYM_W'($urandom_range(255));
        item.code_bits   = $urandom();
        item.code_length = hcbp_pkg::LEN_W'($urandom_range(63));
        pick = $urandom_range(99);
        if (loaded_symbols.size() == 0 || pick < (encode_heavy ? 5 : 20)) begin
            item.mode = hcbp_pkg::MODE_LOAD;
            case ($urandom_range(9))
                0:       item.code_length = '0;
                1:       item.code_length = hcbp_pkg::LEN_W'($urandom_range(63, 33)); // saturates
                2, 3:    item.code_length = hcbp_pkg::LEN_W'($urandom_range(32, 17));
                default: item.code_length = hcbp_pkg::LEN_W'($urandom_range(12, 1));
            endcase
        end else if (pick < (encode_heavy ? 94 : 82)) begin
            item.mode        = hcbp_pkg::MODE_ENCODE;
            item.symbol_byte = loaded_symbols[$urandom_range(loaded_symbols.size() - 1)];
        end else if (pick < 97) begin
            item.mode = hcbp_pkg::MODE_FLUSH;
        end
        return item;
    endfunction

    // valid stays high from one transfer to the next unless a gap is taken
    task automatic send_item(input hcbp_pkg::in_t item);
        while (gaps_enabled && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        if (item.mode == hcbp_pkg::MODE_LOAD && !entry_loaded[item.symbol_byte]) begin
            entry_loaded[item.symbol_byte] = 1'b1;
            loaded_symbols = {loaded_symbols, item.symbol_byte};
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // sender pauses until every predicted byte has been seen
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_awaited != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: longest codes, saturated length, stray code bits, zero length
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32));
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'hFF, 32'h0000_0000, 6'd63));
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'h55, 32'hAAAA_AAA5, 6'd5));
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'hAA, 32'h1234_5678, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd1));
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'h80, 32'h0000_002D, 6'd7));
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'h7F, 32'h8000_0001, 6'd33));
        // four full bytes of ones, then of zeros
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h00, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'hFF, 32'h0, 6'd0));
        // zero-length code and a flush with nothing pending give no byte
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'hAA, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_FLUSH, 8'h00, 32'h0, 6'd0));
        // single bit, then a partial byte flushed out
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h01, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
        // codes straddling byte boundaries
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h55, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h80, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h7F, 32'h0, 6'd0));
        send_item(make_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
        send_item(make_item(hcbp_pkg::MODE_FLUSH, 8'h00, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_FLUSH, 8'h00, 32'h0, 6'd0));
        // overwrite an entry and use it
        send_item(make_item(hcbp_pkg::MODE_LOAD, 8'h00, 32'hFFFF_FFC3, 6'd8));
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h00, 32'h0, 6'd0));
        send_item(make_item(hcbp_pkg::MODE_ENCODE, 8'h01, 32'h0, 6'd0));
        wait_for_drain();

        // random traffic with idling on both sides
        repeat (120) send_item(random_item(1'b0));

        // stretch with no idling anywhere
        gaps_enabled <= 1'b0;
        repeat (60) send_item(random_item(1'b0));

        // receiver holds off while the sender keeps offering, block backs up
        hold_off_request <= 1'b1;
        repeat (40) send_item(random_item(1'b1));
        gaps_enabled <= 1'b1;
        wait_for_drain();

        repeat (140) send_item(random_item(1'b0));
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && bytes_awaited == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
